// ===== rtl/ste_pkg.sv =====
// shared types and constants for the semaphore table engine
// no dependencies; front, back, top and checker refer to this package by scoped name
`timescale 1ns / 1ps
`default_nettype none

package ste_pkg;

	// default sizing, handed to the top level parameters
	localparam int NUM_SEMS_DEF   = 16;
	localparam int WAIT_DEPTH_DEF = 16;
	localparam int PID_BITS_DEF   = 8;
	localparam int COUNT_BITS_DEF = 16;

	// fixed field widths of the words on the ports
	localparam int SEM_ID_W  = 4;
	localparam int INIT_W    = 16;
	localparam int PID_W     = 8;
	localparam int CNT_OUT_W = 16;

	// depth of the small queues between front, back and result port
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_DESTROY = 2'd1,
		CMD_WAIT    = 2'd2,
		CMD_POST    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ERR  = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_EXEC = 2'd1,
		BK_WAKE = 2'd2
	} bk_state_t;

	typedef struct packed {
		cmd_t                  command;
		logic [SEM_ID_W-1:0]   sem_id;
		logic [INIT_W-1:0]     init_value;
		logic [PID_W-1:0]      caller_pid;
	} in_word_t;

	typedef struct packed {
		status_t               status;
		logic [SEM_ID_W-1:0]   result_id;
		logic [CNT_OUT_W-1:0]  count_now;
		logic                  caller_blocked;
		logic                  wake_valid;
		logic [PID_W-1:0]      wake_pid;
	} out_word_t;

	// command word after classification by the front end
	typedef struct packed {
		in_word_t              word;
		logic                  id_in_range;
		logic                  pid_zero;
	} cls_word_t;

	// result handed from the back end to the result queue
	typedef struct packed {
		logic                  push;
		out_word_t             word;
	} res_push_t;

endpackage

`default_nettype wire

// ===== rtl/ste_ram.sv =====
// generic single-port-write ram with one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ste_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [W-1:0]             wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [W-1:0]             rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/ste_fifo.sv =====
// small register-based word queue with full and empty flags
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ste_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] din,
	output logic              full,
	input  wire logic         pop,
	output logic      [W-1:0] dout,
	output logic              empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// storage needs no reset
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ste_front.sv =====
// front end: accepts command words, flags bad ids and zero pids, queues them
// depends on ste_pkg and ste_fifo
`timescale 1ns / 1ps
`default_nettype none

module ste_front #(
	parameter int NUM_SEMS = ste_pkg::NUM_SEMS_DEF,
	parameter int PID_BITS = ste_pkg::PID_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire ste_pkg::in_word_t item,
	output logic                   full,
	input  wire logic              cmd_pop,
	output logic                   cmd_empty,
	output ste_pkg::cls_word_t     cmd_word
);

	localparam int CW = $bits(ste_pkg::cls_word_t);

	ste_pkg::cls_word_t cls;
	logic [CW-1:0]      q_dout;

	always_comb begin
		cls.word        = item;
		cls.id_in_range = (32'(item.sem_id) < NUM_SEMS);
		// pid is kept to its configured width before the zero test
		cls.pid_zero    = (PID_BITS'(item.caller_pid) == '0);
	end

	ste_fifo #(
		.W     (CW),
		.DEPTH (ste_pkg::QUEUE_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cls),
		.full   (full),
		.pop    (cmd_pop),
		.dout   (q_dout),
		.empty  (cmd_empty)
	);

	assign cmd_word = ste_pkg::cls_word_t'(q_dout);

endmodule

`default_nettype wire

// ===== rtl/ste_back.sv =====
// back end: semaphore table, free-id list and wait queues, one command at a time
// depends on ste_pkg and ste_ram
`timescale 1ns / 1ps
`default_nettype none

module ste_back #(
	parameter int NUM_SEMS   = ste_pkg::NUM_SEMS_DEF,
	parameter int WAIT_DEPTH = ste_pkg::WAIT_DEPTH_DEF,
	parameter int PID_BITS   = ste_pkg::PID_BITS_DEF,
	parameter int COUNT_BITS = ste_pkg::COUNT_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_empty,
	input  wire ste_pkg::cls_word_t cmd_word,
	output logic                    cmd_pop,
	input  wire logic               out_full,
	output ste_pkg::res_push_t      res
);

	localparam int SEM_W   = $clog2(NUM_SEMS);
	localparam int FS_W    = $clog2(NUM_SEMS + 1);
	localparam int WQ_W    = $clog2(WAIT_DEPTH);
	localparam int WS_W    = $clog2(WAIT_DEPTH + 1);
	localparam int WQ_AW   = SEM_W + WQ_W;
	localparam int WQ_SIZE = 2 ** WQ_AW;

	typedef struct packed {
		logic [COUNT_BITS-1:0] count;
		logic [WQ_W-1:0]       head;
		logic [WS_W-1:0]       size;
	} tbl_t;

	localparam int TBL_W = $bits(tbl_t);

	ste_pkg::bk_state_t    state_q, state_d;
	ste_pkg::cls_word_t    item_q, item_d;
	logic [SEM_W-1:0]      free_head_q, free_head_d;
	logic [FS_W-1:0]       free_size_q, free_size_d;
	logic [NUM_SEMS-1:0]   free_valid_q, free_valid_d;
	logic [NUM_SEMS-1:0]   alloc_q, alloc_d;
	logic [COUNT_BITS-1:0] wake_cnt_q, wake_cnt_d;

	// ram ports
	logic                  tbl_we;
	logic [SEM_W-1:0]      tbl_waddr;
	tbl_t                  tbl_wdata;
	logic [TBL_W-1:0]      tbl_rdata;
	logic                  free_we;
	logic [SEM_W-1:0]      free_rdata;
	logic                  wq_we;
	logic [WQ_AW-1:0]      wq_waddr;
	logic [WQ_AW-1:0]      wq_raddr;
	logic [PID_BITS-1:0]   wq_rdata;

	// working values of the command in hand
	tbl_t                  tbl_rd;
	logic [SEM_W-1:0]      idx;
	logic [SEM_W-1:0]      fetch_idx;
	logic                  id_ok;
	logic [SEM_W-1:0]      got;
	logic [FS_W:0]         ftail_sum;
	logic [SEM_W-1:0]      free_tail;
	logic [WS_W:0]         wtail_sum;
	logic [WQ_W-1:0]       wq_tail;
	logic [WQ_W-1:0]       wq_head_inc;
	logic [COUNT_BITS-1:0] init_c;
	logic [PID_BITS-1:0]   pid_c;
	logic [COUNT_BITS-1:0] cnt_dec;
	logic [COUNT_BITS-1:0] cnt_sat;

	assign tbl_rd    = tbl_t'(tbl_rdata);
	assign idx       = SEM_W'(item_q.word.sem_id);
	assign fetch_idx = SEM_W'(cmd_word.word.sem_id);
	assign id_ok     = item_q.id_in_range && alloc_q[idx];
	assign got       = free_valid_q[free_head_q] ? free_rdata : free_head_q;
	assign init_c    = COUNT_BITS'(item_q.word.init_value);
	assign pid_c     = PID_BITS'(item_q.word.caller_pid);
	assign cnt_dec   = tbl_rd.count - 1'b1;
	assign cnt_sat   = (&tbl_rd.count) ? tbl_rd.count : tbl_rd.count + 1'b1;

	// free list tail, head plus size wrapped once
	assign ftail_sum = (FS_W + 1)'(free_head_q) + (FS_W + 1)'(free_size_q);
	assign free_tail = (ftail_sum >= (FS_W + 1)'(NUM_SEMS))
		? SEM_W'(ftail_sum - (FS_W + 1)'(NUM_SEMS)) : SEM_W'(ftail_sum);

	// wait queue tail and next head
	assign wtail_sum   = (WS_W + 1)'(tbl_rd.head) + (WS_W + 1)'(tbl_rd.size);
	assign wq_tail     = (wtail_sum >= (WS_W + 1)'(WAIT_DEPTH))
		? WQ_W'(wtail_sum - (WS_W + 1)'(WAIT_DEPTH)) : WQ_W'(wtail_sum);
	assign wq_head_inc = (tbl_rd.head == WQ_W'(WAIT_DEPTH - 1)) ? '0 : tbl_rd.head + 1'b1;

	assign wq_waddr = {idx, wq_tail};
	assign wq_raddr = {idx, tbl_rd.head};

	always_comb begin
		state_d      = state_q;
		item_d       = item_q;
		free_head_d  = free_head_q;
		free_size_d  = free_size_q;
		free_valid_d = free_valid_q;
		alloc_d      = alloc_q;
		wake_cnt_d   = wake_cnt_q;
		cmd_pop      = 1'b0;
		tbl_we       = 1'b0;
		tbl_waddr    = idx;
		tbl_wdata    = tbl_rd;
		free_we      = 1'b0;
		wq_we        = 1'b0;
		res.push     = 1'b0;
		res.word     = '{status: ste_pkg::ST_OK, default: '0};

		unique case (state_q)
			ste_pkg::BK_IDLE: begin
				// result queue room is checked up front so a started command never stalls
				if (!cmd_empty && !out_full) begin
					cmd_pop = 1'b1;
					item_d  = cmd_word;
					state_d = ste_pkg::BK_EXEC;
				end
			end
			ste_pkg::BK_EXEC: begin
				state_d  = ste_pkg::BK_IDLE;
				res.push = 1'b1;
				unique case (item_q.word.command)
					ste_pkg::CMD_ALLOC: begin
						if (free_size_q == '0) begin
							res.word.status = ste_pkg::ST_ERR;
						end else begin
							free_head_d = (free_head_q == SEM_W'(NUM_SEMS - 1))
								? '0 : free_head_q + 1'b1;
							free_size_d  = free_size_q - 1'b1;
							alloc_d[got] = 1'b1;
							tbl_we       = 1'b1;
							tbl_waddr    = got;
							tbl_wdata    = '{count: init_c, head: '0, size: '0};
							res.word.result_id = ste_pkg::SEM_ID_W'(got);
							res.word.count_now = ste_pkg::CNT_OUT_W'(init_c);
						end
					end
					ste_pkg::CMD_DESTROY: begin
						if (!id_ok || tbl_rd.count != '0 || free_size_q >= FS_W'(NUM_SEMS)) begin
							res.word.status = ste_pkg::ST_ERR;
						end else begin
							// waiters are dropped: allocate clears the queue pointers
							free_we                 = 1'b1;
							free_valid_d[free_tail] = 1'b1;
							free_size_d             = free_size_q + 1'b1;
							alloc_d[idx]            = 1'b0;
						end
					end
					ste_pkg::CMD_WAIT, ste_pkg::CMD_POST: begin
						priority if (item_q.pid_zero || !id_ok) begin
							res.word.status = ste_pkg::ST_ERR;
						end else if (item_q.word.command == ste_pkg::CMD_WAIT) begin
							if (tbl_rd.count == '0) begin
								if (tbl_rd.size >= WS_W'(WAIT_DEPTH)) begin
									res.word.status = ste_pkg::ST_FULL;
								end else begin
									wq_we          = 1'b1;
									tbl_we         = 1'b1;
									tbl_wdata.size = tbl_rd.size + 1'b1;
									res.word.caller_blocked = 1'b1;
								end
							end else begin
								tbl_we          = 1'b1;
								tbl_wdata.count = cnt_dec;
								res.word.count_now = ste_pkg::CNT_OUT_W'(cnt_dec);
							end
						end else if (tbl_rd.size != '0) begin
							// hand off: fetch the oldest waiter, answer next cycle
							tbl_we         = 1'b1;
							tbl_wdata.head = wq_head_inc;
							tbl_wdata.size = tbl_rd.size - 1'b1;
							wake_cnt_d     = tbl_rd.count;
							res.push       = 1'b0;
							state_d        = ste_pkg::BK_WAKE;
						end else begin
							tbl_we          = 1'b1;
							tbl_wdata.count = cnt_sat;
							res.word.count_now = ste_pkg::CNT_OUT_W'(cnt_sat);
						end
					end
				endcase
			end
			ste_pkg::BK_WAKE: begin
				state_d             = ste_pkg::BK_IDLE;
				res.push            = 1'b1;
				res.word.count_now  = ste_pkg::CNT_OUT_W'(wake_cnt_q);
				res.word.wake_valid = 1'b1;
				res.word.wake_pid   = ste_pkg::PID_W'(wq_rdata);
			end
			default: begin
				state_d = ste_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ste_pkg::BK_IDLE;
			free_head_q  <= '0;
			free_size_q  <= FS_W'(NUM_SEMS);
			free_valid_q <= '0;
			alloc_q      <= '0;
		end else begin
			state_q      <= state_d;
			free_head_q  <= free_head_d;
			free_size_q  <= free_size_d;
			free_valid_q <= free_valid_d;
			alloc_q      <= alloc_d;
		end
	end

	always_ff @(posedge clk) begin
		item_q     <= item_d;
		wake_cnt_q <= wake_cnt_d;
	end

	// count, wait head and wait size per semaphore; read at the queue head id
	ste_ram #(
		.W     (TBL_W),
		.DEPTH (NUM_SEMS)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (fetch_idx),
		.rdata (tbl_rdata)
	);

	// free id list; an entry never written stands for its own index, by its valid bit
	ste_ram #(
		.W     (SEM_W),
		.DEPTH (NUM_SEMS)
	) u_free_ram (
		.clk   (clk),
		.we    (free_we),
		.waddr (free_tail),
		.wdata (idx),
		.raddr (free_head_q),
		.rdata (free_rdata)
	);

	// waiting pids, one row of slots per semaphore
	ste_ram #(
		.W     (PID_BITS),
		.DEPTH (WQ_SIZE)
	) u_wait_ram (
		.clk   (clk),
		.we    (wq_we),
		.waddr (wq_waddr),
		.wdata (pid_c),
		.raddr (wq_raddr),
		.rdata (wq_rdata)
	);

endmodule

`default_nettype wire

// ===== rtl/semaphore_table_engine_top.sv =====
// path: a pushed word passes the front queue, then the back end's idle and exec states,
// then the result queue; a post that wakes a waiter passes the wake state after exec
// the back end starts a command only once the last is done: the table ram is read,
// then written back, and a waking post also reads the wait-queue ram in the wake state
// reset: arst_n clears all control state at once; the free-id list reads through
// per-entry valid bits, so no clearing pass is needed and push is taken straight away
`timescale 1ns / 1ps
`default_nettype none

module semaphore_table_engine_top #(
	parameter int NUM_SEMS   = ste_pkg::NUM_SEMS_DEF,
	parameter int WAIT_DEPTH = ste_pkg::WAIT_DEPTH_DEF,
	parameter int PID_BITS   = ste_pkg::PID_BITS_DEF,
	parameter int COUNT_BITS = ste_pkg::COUNT_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// command side
	input  wire logic              push,
	input  wire ste_pkg::in_word_t item,
	output logic                   full,
	// result side
	output logic                   empty,
	input  wire logic              pop,
	output ste_pkg::out_word_t     result
);

	localparam int OW = $bits(ste_pkg::out_word_t);

	// front to back: classified command words through a two-word queue
	logic               cmd_pop;
	logic               cmd_empty;
	ste_pkg::cls_word_t cmd_word;

	// back to result queue
	ste_pkg::res_push_t res;
	logic               out_full;
	logic [OW-1:0]      out_dout;

	// front end takes a word whenever its queue has room, whatever the back is doing
	ste_front #(
		.NUM_SEMS (NUM_SEMS),
		.PID_BITS (PID_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.cmd_pop   (cmd_pop),
		.cmd_empty (cmd_empty),
		.cmd_word  (cmd_word)
	);

	// back end runs one command at a time against the tables
	ste_back #(
		.NUM_SEMS   (NUM_SEMS),
		.WAIT_DEPTH (WAIT_DEPTH),
		.PID_BITS   (PID_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_word  (cmd_word),
		.cmd_pop   (cmd_pop),
		.out_full  (out_full),
		.res       (res)
	);

	// result queue decouples the back end from a stalled consumer;
	// the back end only starts a command when a slot is free
	ste_fifo #(
		.W     (OW),
		.DEPTH (ste_pkg::QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res.push),
		.din    (res.word),
		.full   (out_full),
		.pop    (pop),
		.dout   (out_dout),
		.empty  (empty)
	);

	assign result = ste_pkg::out_word_t'(out_dout);

endmodule

`default_nettype wire

// ===== rtl/ste_checker.sv =====
// port-level checks of the result side, bound to the top level
// depends on ste_pkg and semaphore_table_engine_top
`timescale 1ns / 1ps
`default_nettype none

module ste_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               empty,
	input wire logic               pop,
	input wire ste_pkg::out_word_t result
);

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed while stalled");

	// a failed command carries nothing but its status
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status != ste_pkg::ST_OK) |->
		(result.result_id == '0 && result.count_now == '0 && !result.caller_blocked
		 && !result.wake_valid && result.wake_pid == '0))
		else $error("error result with non-zero fields");

	// a blocked caller leaves the count at zero and wakes nobody
	a_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.caller_blocked) |->
		(result.status == ste_pkg::ST_OK && !result.wake_valid
		 && result.count_now == '0 && result.result_id == '0))
		else $error("blocked result inconsistent");

	// a wake comes only from a successful post
	a_wake: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.wake_valid) |->
		(result.status == ste_pkg::ST_OK && !result.caller_blocked
		 && result.result_id == '0))
		else $error("wake result inconsistent");

endmodule

bind semaphore_table_engine_top ste_checker u_ste_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for semaphore_table_engine_top: directed then random commands
// needs ste_pkg and the engine top level; the scoreboard class predicts each result word
`timescale 1ns / 1ps

module testbench;
	import ste_pkg::*;

	localparam int NS = NUM_SEMS_DEF;
	localparam int WD = WAIT_DEPTH_DEF;
	localparam int CLK_HALF = 4;

	// sizes the drain of a semaphore before it is destroyed, and caps the slow ones
	localparam int DRAIN_MAX = 40;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	in_word_t  item = '0;
	logic      full;
	logic      empty;
	logic      pop = 1'b0;
	out_word_t result;

	int words_sent = 0;
	bit push_burst = 1'b0;
	bit pop_burst = 1'b0;

	semaphore_table_engine_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	// own copy of the semaphore table, free-id list and wait queues
	class sem_table_predictor;
		logic [3:0]  free_ids [NS];
		int          free_head;
		int          free_size;
		logic [15:0] sem_count [NS];
		bit          sem_alloc [NS];
		logic [7:0]  wait_pid [NS][WD];
		int          wait_head [NS];
		int          wait_size [NS];
		out_word_t   due_results [$];
		int          fail_count;
		int          results_seen;

		function new();
			for (int i = 0; i < NS; i++) begin
				free_ids[i] = 4'(i);
				sem_count[i] = '0;
				sem_alloc[i] = 1'b0;
				wait_head[i] = 0;
				wait_size[i] = 0;
				for (int j = 0; j < WD; j++)
					wait_pid[i][j] = '0;
			end
			free_head = 0;
			free_size = NS;
			fail_count = 0;
			results_seen = 0;
		endfunction

		// works out the result of one accepted command and updates the table
		function void note_command(in_word_t w);
			out_word_t r;
			int id;
			int got;
			bit id_ok;
			r = '0;
			r.status = ST_OK;
			id = int'(w.sem_id);
			id_ok = (id < NS) && sem_alloc[id];
			case (w.command)
				CMD_ALLOC: begin
					if (free_size == 0) begin
						r.status = ST_ERR;
					end else begin
						got = int'(free_ids[free_head]);
						free_head = (free_head + 1) % NS;
						free_size--;
						sem_alloc[got] = 1'b1;
						sem_count[got] = w.init_value;
						wait_head[got] = 0;
						wait_size[got] = 0;
						r.result_id = 4'(got);
						r.count_now = w.init_value;
					end
				end
				CMD_DESTROY: begin
					if (!id_ok || sem_count[id] != 0 || free_size >= NS) begin
						r.status = ST_ERR;
					end else begin
						// any waiters go with the semaphore
						free_ids[(free_head + free_size) % NS] = 4'(id);
						free_size++;
						sem_alloc[id] = 1'b0;
						sem_count[id] = '0;
						wait_head[id] = 0;
						wait_size[id] = 0;
					end
				end
				default: begin
					if (w.caller_pid == '0 || !id_ok) begin
						r.status = ST_ERR;
					end else if (w.command == CMD_WAIT) begin
						if (sem_count[id] != 0) begin
							sem_count[id]--;
							r.count_now = sem_count[id];
						end else if (wait_size[id] >= WD) begin
							r.status = ST_FULL;
						end else begin
							wait_pid[id][(wait_head[id] + wait_size[id]) % WD] = w.caller_pid;
							wait_size[id]++;
							r.caller_blocked = 1'b1;
						end
					end else if (wait_size[id] > 0) begin
						// post hands the unit straight to the oldest waiter
						r.wake_valid = 1'b1;
						r.wake_pid = wait_pid[id][wait_head[id]];
						wait_head[id] = (wait_head[id] + 1) % WD;
						wait_size[id]--;
						r.count_now = sem_count[id];
					end else begin
						if (sem_count[id] != '1)
							sem_count[id]++;
						r.count_now = sem_count[id];
					end
				end
			endcase
			due_results.push_back(r);
		endfunction

		task report(string msg);
			fail_count++;
			if (fail_count <= 40)
				$display("mismatch at result %0d: %s", results_seen, msg);
		endtask

		task check_result(out_word_t got);
			out_word_t want;
			results_seen++;
			if (due_results.size() == 0) begin
				report("result word with nothing outstanding");
				return;
			end
			want = due_results.pop_front();
			if (got.status !== want.status)
				report($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.result_id !== want.result_id)
				report($sformatf("result_id %0d, want %0d", got.result_id, want.result_id));
			if (got.count_now !== want.count_now)
				report($sformatf("count_now %0d, want %0d", got.count_now, want.count_now));
			if (got.caller_blocked !== want.caller_blocked)
				report($sformatf("caller_blocked %b, want %b",
					got.caller_blocked, want.caller_blocked));
			if (got.wake_valid !== want.wake_valid)
				report($sformatf("wake_valid %b, want %b", got.wake_valid, want.wake_valid));
			if (got.wake_pid !== want.wake_pid)
				report($sformatf("wake_pid %0d, want %0d", got.wake_pid, want.wake_pid));
		endtask
	endclass

	sem_table_predictor model = new();

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	function automatic in_word_t cmd_word(cmd_t c, int id, int v, int p);
		in_word_t w;
		w.command = c;
		w.sem_id = 4'(id);
		w.init_value = 16'(v);
		w.caller_pid = 8'(p);
		return w;
	endfunction

	// one word in; push stays high across back-to-back words
	task automatic send_command(in_word_t w);
		int gap;
		if ($urandom_range(0, 63) == 0)
			push_burst = !push_burst;
		gap = push_burst ? 0 : int'($urandom_range(0, 14));
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		do @(posedge clk); while (full);
		model.note_command(w);
		words_sent++;
	endtask

	function automatic int pick_id();
		int live [$];
		for (int i = 0; i < NS; i++)
			if (model.sem_alloc[i])
				live.push_back(i);
		if (live.size() != 0 && $urandom_range(0, 6) != 0)
			return live[$urandom_range(0, live.size() - 1)];
		return int'($urandom_range(0, 15));
	endfunction

	// mostly live pids, now and then the rejected zero pid
	function automatic int pick_pid();
		if ($urandom_range(0, 24) == 0)
			return 0;
		return int'($urandom_range(1, 255));
	endfunction

	function automatic int slow_sems();
		int n = 0;
		for (int i = 0; i < NS; i++)
			if (model.sem_alloc[i] && model.sem_count[i] > DRAIN_MAX)
				n++;
		return n;
	endfunction

	// large counts cannot be drained back to zero, so only a few are allowed at once
	function automatic int pick_init();
		int r;
		r = int'($urandom_range(0, 9));
		if (r < 7)
			return int'($urandom_range(0, 3));
		if (r == 7)
			return int'($urandom_range(4, 12));
		if (slow_sems() < 3)
			return ($urandom_range(0, 1) != 0) ? int'($urandom_range(0, 65535)) : 65535;
		return int'($urandom_range(0, 3));
	endfunction

	task automatic random_mix(int n);
		int r;
		repeat (n) begin
			r = int'($urandom_range(0, 19));
			if (r < 4)
				send_command(cmd_word(CMD_ALLOC, $urandom_range(0, 15), pick_init(),
					$urandom_range(0, 255)));
			else if (r < 7)
				send_command(cmd_word(CMD_DESTROY, pick_id(), $urandom_range(0, 65535),
					$urandom_range(0, 255)));
			else if (r < 14)
				send_command(cmd_word(CMD_WAIT, pick_id(), $urandom_range(0, 65535),
					pick_pid()));
			else
				send_command(cmd_word(CMD_POST, pick_id(), $urandom_range(0, 65535),
					pick_pid()));
		end
	endtask

	// piles waiters onto a zero-count semaphore up to and past the queue depth, then posts some or all out
	task automatic flood_queue();
		int id = -1;
		int start;
		int n;
		start = int'($urandom_range(0, NS - 1));
		for (int k = 0; k < NS; k++)
			if (id < 0 && model.sem_alloc[(start + k) % NS] &&
					model.sem_count[(start + k) % NS] == 0)
				id = (start + k) % NS;
		if (id < 0) begin
			if (model.free_size == 0)
				return;
			id = int'(model.free_ids[model.free_head]);
			send_command(cmd_word(CMD_ALLOC, $urandom_range(0, 15), 0, pick_pid()));
		end
		n = int'($urandom_range(WD - 3, WD + 3));
		repeat (n)
			send_command(cmd_word(CMD_WAIT, id, $urandom_range(0, 65535), pick_pid()));
		repeat ($urandom_range(n / 2, n + 2))
			send_command(cmd_word(CMD_POST, id, $urandom_range(0, 65535), pick_pid()));
	endtask

	// drains small counts to zero and destroys, freeing ids for later allocates
	task automatic recycle();
		int start;
		int id;
		start = int'($urandom_range(0, NS - 1));
		for (int k = 0; k < NS; k++) begin
			id = (start + k) % NS;
			if (model.sem_alloc[id] && $urandom_range(0, 3) != 0) begin
				if (model.sem_count[id] <= DRAIN_MAX)
					while (model.sem_count[id] != 0)
						send_command(cmd_word(CMD_WAIT, id, $urandom_range(0, 65535),
							$urandom_range(1, 255)));
				send_command(cmd_word(CMD_DESTROY, id, $urandom_range(0, 65535),
					$urandom_range(0, 255)));
			end
		end
	endtask

	task automatic exhaust_ids();
		while (model.free_size != 0)
			send_command(cmd_word(CMD_ALLOC, $urandom_range(0, 15), $urandom_range(0, 2),
				$urandom_range(0, 255)));
		// allocates with no id left must fail
		repeat ($urandom_range(1, 2))
			send_command(cmd_word(CMD_ALLOC, $urandom_range(0, 15), $urandom_range(0, 65535),
				$urandom_range(0, 255)));
		recycle();
	endtask

	task automatic saturate();
		int id;
		if (slow_sems() >= 3 || model.free_size == 0)
			return;
		id = int'(model.free_ids[model.free_head]);
		send_command(cmd_word(CMD_ALLOC, 0, 65535 - int'($urandom_range(0, 2)), pick_pid()));
		repeat ($urandom_range(2, 5))
			send_command(cmd_word(CMD_POST, id, $urandom_range(0, 65535), pick_pid()));
		repeat ($urandom_range(0, 3))
			send_command(cmd_word(CMD_WAIT, id, $urandom_range(0, 65535), pick_pid()));
	endtask

	// result side: random pop gaps, each accepted word checked in order
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 63) == 0)
				pop_burst = !pop_burst;
			gap = pop_burst ? 0 : int'($urandom_range(0, 14));
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			model.check_result(result);
		end
	end

	// stimulus and end of run
	initial begin
		int r;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ids come out 0, 1, 2 from a fresh free list
		send_command(cmd_word(CMD_ALLOC, 0, 0, 1));
		send_command(cmd_word(CMD_ALLOC, 15, 16'hFFFF, 8'hFF));
		send_command(cmd_word(CMD_ALLOC, 0, 5, 0));
		send_command(cmd_word(CMD_WAIT, 0, 0, 8'hFF));
		send_command(cmd_word(CMD_WAIT, 0, 0, 0));
		send_command(cmd_word(CMD_POST, 1, 16'hFFFF, 1));
		send_command(cmd_word(CMD_WAIT, 1, 0, 8'h80));
		send_command(cmd_word(CMD_POST, 0, 0, 8'h55));
		send_command(cmd_word(CMD_POST, 0, 0, 0));
		send_command(cmd_word(CMD_DESTROY, 2, 0, 7));
		send_command(cmd_word(CMD_DESTROY, 15, 0, 7));
		send_command(cmd_word(CMD_WAIT, 15, 0, 3));
		send_command(cmd_word(CMD_POST, 15, 0, 3));
		send_command(cmd_word(CMD_WAIT, 0, 16'hFFFF, 8'hAA));
		send_command(cmd_word(CMD_WAIT, 0, 0, 8'h2A));
		send_command(cmd_word(CMD_DESTROY, 0, 16'hFFFF, 0));
		send_command(cmd_word(CMD_POST, 0, 0, 1));
		send_command(cmd_word(CMD_ALLOC, 8, 16'hAAAA, 8'h55));
		send_command(cmd_word(CMD_ALLOC, 7, 16'h5555, 0));
		send_command(cmd_word(CMD_WAIT, 2, 0, 8'h01));
		send_command(cmd_word(CMD_POST, 2, 0, 8'hFE));

		// random: the full wait queue and the empty free list first, then a mix
		flood_queue();
		exhaust_ids();
		while (words_sent < 1820) begin
			r = int'($urandom_range(0, 9));
			if (r < 6)
				random_mix(int'($urandom_range(5, 30)));
			else if (r == 6)
				flood_queue();
			else if (r == 7)
				exhaust_ids();
			else if (r == 8)
				recycle();
			else
				saturate();
		end
		push <= 1'b0;

		while (model.due_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (model.fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// hang guard, several times the slowest legal run
	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
